FILE: hw/rtl/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

    localparam int unsigned NUM_STREAMS   = 8;
    localparam int unsigned MS_PER_SECOND = 1000;

    localparam int unsigned ADDR_W  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STREAM_W = 3;
    localparam int unsigned IDX_W   = 32;
    localparam int unsigned IFACE_W = 16;
    localparam int unsigned GM_W    = 64;
    localparam int unsigned DOM_W   = 8;
    localparam int unsigned SECS_W  = 8;
    localparam int unsigned REM_W   = 18;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 64;

    typedef enum logic [OP_W-1:0] {
        OP_AVAILABLE = 2'd0,
        OP_DEPARTING = 2'd1,
        OP_TICK      = 2'd2,
        OP_RESET     = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        NOTICE_DISCOVERED = 1'b0,
        NOTICE_DEPARTED   = 1'b1
    } notice_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GM_ID  = 1'b0,
        REG_DOMAIN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic               disc;
        logic [IDX_W-1:0]   avail;
        logic [IFACE_W-1:0] iface;
        logic [REM_W-1:0]   rem;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: hw/rtl/tdt_if.sv
`default_nettype none

interface tdt_item_if;
    import tdt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [STREAM_W-1:0] stream;
    logic [IDX_W-1:0]    msg_available_index;
    logic [IFACE_W-1:0]  msg_interface_index;
    logic [GM_W-1:0]     msg_grandmaster_id;
    logic [DOM_W-1:0]    msg_domain;
    logic [SECS_W-1:0]   valid_seconds;

    modport source (
        output valid, operation, stream, msg_available_index, msg_interface_index,
               msg_grandmaster_id, msg_domain, valid_seconds,
        input  ready
    );
    modport sink (
        input  valid, operation, stream, msg_available_index, msg_interface_index,
               msg_grandmaster_id, msg_domain, valid_seconds,
        output ready
    );
endinterface

interface tdt_result_if;
    import tdt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STREAM_W-1:0] out_stream;
    logic                notice;
    logic                last;

    modport source (output valid, out_stream, notice, last, input ready);
    modport sink (input valid, out_stream, notice, last, output ready);
endinterface

interface tdt_cfg_if;
    import tdt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tdt_ram.sv
`default_nettype none

module tdt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/talker_discovery_tracker_core.sv
// Talker discovery tracker, one entry per listener stream.
// item: valid/ready channel. available, departing and reset-stream transactions
//   act on one stream; a tick transaction counts down the timer of every stream.
// result: valid/ready channel of status notices (discovered/departed); last marks
//   the final notice of a transaction. Transactions with no effect give none.
// cfg: valid/ready write channel, always ready; index 0 grandmaster id,
//   index 1 domain. Write only while the tracker is idle.
// One transaction is processed at a time; ready is high only while idle.
// Stream state sits in an 8-entry RAM with a registered read.
// Message: read in S_IDLE, update in S_MSG (then S_MSG2 on a restart that rediscovers), then S_FIN.
// Tick: one read-modify-write of the RAM per stream, then S_FIN.
// Each notice waits in a hold register so the last flag can be set, then goes to a
// one-deep output register; a stalled receiver stalls the walk only when a
// second notice is waiting. Reset clears per-stream valid bits, so every entry
// reads as zero until written; no clearing pass is needed.
`default_nettype none

module talker_discovery_tracker_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tdt_item_if.sink      item,
    tdt_result_if.source  result,
    tdt_cfg_if.sink       cfg
);
    import tdt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MSG  = 5'b00010,
        S_MSG2 = 5'b00100,
        S_TICK = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_STREAMS - 1);
    localparam logic [REM_W-1:0]  MS_MULT  = REM_W'(MS_PER_SECOND);

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [STREAM_W-1:0]  stream_reg;
    logic [IDX_W-1:0]     midx_reg;
    logic [IFACE_W-1:0]   miface_reg;
    logic                 gok_reg;
    logic [REM_W-1:0]     load_reg;
    logic [ADDR_W-1:0]    idx_reg, idx_next;

    logic [GM_W-1:0]      gm_reg;
    logic [DOM_W-1:0]     dom_reg;

    logic [NUM_STREAMS-1:0] vld_reg;
    logic                 rd_vld_reg;

    logic                 hold_valid_reg;
    logic [STREAM_W-1:0]  hold_stream_reg;
    notice_t              hold_notice_reg;

    logic                 out_valid_reg;
    logic [STREAM_W-1:0]  out_stream_reg;
    notice_t              out_notice_reg;
    logic                 out_last_reg;

    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [ENTRY_W-1:0]   rd_data;
    entry_t               entry, wr_entry;

    logic                 produce, flush, push_out, out_free, in_range;
    logic [STREAM_W-1:0]  prod_stream;
    notice_t              prod_notice;
    logic [SECS_W-1:0]    secs_eff;
    logic [REM_W-1:0]     load_value;

    tdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_STREAMS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item.ready    = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.out_stream = out_stream_reg;
    assign result.notice     = out_notice_reg;
    assign result.last       = out_last_reg;

    assign entry    = rd_vld_reg ? entry_t'(rd_data) : '0;
    assign out_free = !out_valid_reg || result.ready;
    assign push_out = (produce && hold_valid_reg) || flush;
    assign in_range = {{(32 - STREAM_W){1'b0}}, item.stream} < NUM_STREAMS;
    assign secs_eff = (item.valid_seconds == '0) ? SECS_W'(1) : item.valid_seconds;
    assign load_value = REM_W'(secs_eff) * MS_MULT;

    always_comb
    begin
        logic [IDX_W-1:0] diff;
        logic             restart;
        logic             expire;
        logic [REM_W-1:0] rem_dec;

        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_entry    = entry;
        produce     = 1'b0;
        prod_stream = stream_reg;
        prod_notice = NOTICE_DEPARTED;
        flush       = 1'b0;
        diff        = midx_reg - entry.avail;
        restart     = (diff == '0) || diff[IDX_W-1];
        rem_dec     = entry.rem - REM_W'(1);
        expire      = (entry.rem != '0) && (rem_dec == '0) && entry.disc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (op_t'(item.operation) == OP_TICK)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_TICK;
                    end
                    else if (in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(item.stream);
                        state_next = S_MSG;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MSG:
            begin
                wr_en      = 1'b1;
                state_next = S_FIN;
                case (op_reg)
                    OP_AVAILABLE:
                    begin
                        if (!entry.disc)
                        begin
                            if (gok_reg)
                            begin
                                wr_entry.disc  = 1'b1;
                                wr_entry.avail = midx_reg;
                                wr_entry.iface = miface_reg;
                                wr_entry.rem   = load_reg;
                                produce        = 1'b1;
                                prod_notice    = NOTICE_DISCOVERED;
                            end
                        end
                        else if (entry.iface == miface_reg)
                        begin
                            if (restart)
                            begin
                                produce     = 1'b1;
                                prod_notice = NOTICE_DEPARTED;
                            end
                            if (restart && !gok_reg)
                            begin
                                wr_entry.disc = 1'b0;
                                wr_entry.rem  = '0;
                            end
                            else
                            begin
                                wr_entry.avail = midx_reg;
                                wr_entry.rem   = load_reg;
                                if (restart)
                                begin
                                    state_next = S_MSG2;
                                end
                            end
                        end
                    end
                    OP_DEPARTING:
                    begin
                        if (entry.disc && (entry.iface == miface_reg))
                        begin
                            wr_entry.disc = 1'b0;
                            wr_entry.rem  = '0;
                            produce       = 1'b1;
                            prod_notice   = NOTICE_DEPARTED;
                        end
                    end
                    default:
                    begin
                        if (entry.disc)
                        begin
                            wr_entry.disc = 1'b0;
                            wr_entry.rem  = '0;
                        end
                    end
                endcase
            end
            S_MSG2:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    produce     = 1'b1;
                    prod_notice = NOTICE_DISCOVERED;
                    state_next  = S_FIN;
                end
            end
            S_TICK:
            begin
                if (!(expire && hold_valid_reg && !out_free))
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    if (entry.rem != '0)
                    begin
                        wr_entry.rem = rem_dec;
                    end
                    if (expire)
                    begin
                        wr_entry.disc = 1'b0;
                        produce       = 1'b1;
                        prod_stream   = STREAM_W'(idx_reg);
                        prod_notice   = NOTICE_DEPARTED;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            gm_reg         <= '0;
            dom_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (produce)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_GM_ID:  gm_reg  <= cfg.data;
                    REG_DOMAIN: dom_reg <= cfg.data[DOM_W-1:0];
                    default:    gm_reg  <= gm_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg     <= op_t'(item.operation);
            stream_reg <= item.stream;
            addr_reg   <= ADDR_W'(item.stream);
            midx_reg   <= item.msg_available_index;
            miface_reg <= item.msg_interface_index;
            gok_reg    <= (item.msg_grandmaster_id == gm_reg) && (item.msg_domain == dom_reg);
            load_reg   <= load_value;
        end
        if (produce)
        begin
            hold_stream_reg <= prod_stream;
            hold_notice_reg <= prod_notice;
        end
        if (push_out)
        begin
            out_stream_reg <= hold_stream_reg;
            out_notice_reg <= hold_notice_reg;
            out_last_reg   <= flush;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tdt_checker.sv
`default_nettype none

module tdt_props (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   item_valid,
    input wire logic                   item_ready,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire logic [tdt_pkg::STREAM_W-1:0] result_out_stream,
    input wire logic                   result_notice,
    input wire logic                   result_last
);

    // stalled notice holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_out_stream)
            && $stable(result_notice) && $stable(result_last))
        else $error("stalled notice changed");

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while busy");

    // more notices of this transaction still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !item_ready)
        else $error("idle before last notice");

endmodule

bind talker_discovery_tracker_core tdt_props u_tdt_props (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_out_stream (result.out_stream),
    .result_notice     (result.notice),
    .result_last       (result.last)
);

`default_nettype wire
